// ===== sv/keypad_debounce_digit_entry_top_assert.svh =====
// Assertion macros shared by the keypad block.
`ifndef KEYPAD_DEBOUNCE_DIGIT_ENTRY_TOP_ASSERT_SVH
`define KEYPAD_DEBOUNCE_DIGIT_ENTRY_TOP_ASSERT_SVH

// same-cycle implication
`define KPD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad assertion failed");

// next-cycle implication
`define KPD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad assertion failed");

`endif

// ===== sv/kpd_pkg.sv =====
`timescale 1ns / 1ps

package kpd_pkg;

    localparam int DIGITS_DEF      = 4;
    localparam int KEY_ROWS_DEF    = 4;
    localparam int KEY_COLUMNS_DEF = 4;

    localparam logic [15:0] LIMIT_RESET = 16'd400;

    localparam int RING_DEPTH = 4;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TXRDY = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [3:0] KEY_SEND   = 4'd10;

    typedef struct packed {
        logic       display_valid;
        logic [1:0] digit_select;
        logic [7:0] seg_pattern;
        logic       key_valid;
        logic [3:0] key_code;
        logic       tx_valid;
        logic [3:0] tx_byte;
    } t_result;

    function automatic logic [7:0] seg_lookup(input logic [3:0] v);
        logic [7:0] s;
        case (v)
            4'd0:    s = 8'b1100_0000;
            4'd1:    s = 8'b1111_1001;
            4'd2:    s = 8'b1010_0100;
            4'd3:    s = 8'b1011_0000;
            4'd4:    s = 8'b1001_1001;
            4'd5:    s = 8'b1001_0010;
            4'd6:    s = 8'b1000_0010;
            4'd7:    s = 8'b1111_1000;
            4'd8:    s = 8'b1000_0000;
            4'd9:    s = 8'b1001_0000;
            default: s = 8'b1111_1111;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] k;
        case ({row, col})
            4'h0: k = 4'd10;
            4'h1: k = 4'd3;
            4'h2: k = 4'd2;
            4'h3: k = 4'd1;
            4'h4: k = 4'd11;
            4'h5: k = 4'd6;
            4'h6: k = 4'd5;
            4'h7: k = 4'd4;
            4'h8: k = 4'd12;
            4'h9: k = 4'd9;
            4'hA: k = 4'd8;
            4'hB: k = 4'd7;
            4'hC: k = 4'd13;
            4'hD: k = 4'd15;
            4'hE: k = 4'd0;
            default: k = 4'd14;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/kpd_in_if.sv =====
`timescale 1ns / 1ps

interface kpd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] key_matrix;
    logic [7:0]  rx_byte;

    modport source (output valid, output opcode, output key_matrix, output rx_byte,
                    input ready);
    modport sink (input valid, input opcode, input key_matrix, input rx_byte,
                  output ready);
endinterface

// ===== sv/kpd_out_if.sv =====
`timescale 1ns / 1ps

interface kpd_out_if;
    logic       valid;
    logic       ready;
    logic       display_valid;
    logic [1:0] digit_select;
    logic [7:0] seg_pattern;
    logic       key_valid;
    logic [3:0] key_code;
    logic       tx_valid;
    logic [3:0] tx_byte;

    modport source (output valid, output display_valid, output digit_select,
                    output seg_pattern, output key_valid, output key_code,
                    output tx_valid, output tx_byte, input ready);
    modport sink (input valid, input display_valid, input digit_select,
                  input seg_pattern, input key_valid, input key_code,
                  input tx_valid, input tx_byte, output ready);
endinterface

// ===== sv/kpd_cfg_if.sv =====
`timescale 1ns / 1ps

interface kpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/kpd_engine.sv =====
`timescale 1ns / 1ps
`include "keypad_debounce_digit_entry_top_assert.svh"

module kpd_engine #(
    parameter int DIGITS      = 4,
    parameter int KEY_ROWS    = 4,
    parameter int KEY_COLUMNS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [15:0]       i_key_matrix,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_limit,
    output kpd_pkg::t_result  o_result
);
    import kpd_pkg::*;

    localparam int SCAN_ROWS = (KEY_ROWS > 4) ? 4 : KEY_ROWS;
    localparam int SCAN_COLS = (KEY_COLUMNS > 4) ? 4 : KEY_COLUMNS;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PRESS   = 2'd1;
    localparam logic [1:0] ST_PROCESS = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [15:0]        r_count, n_count;
    logic [1:0]         r_row, n_row;
    logic [1:0]         r_col, n_col;
    logic [RING_AW-1:0] r_wp, n_wp;
    logic [RING_AW-1:0] r_disp, n_disp;
    logic               r_tx_active, n_tx_active;
    logic [2:0]         r_tx_index, n_tx_index;

    logic [3:0]           r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_mem_valid;
    logic [3:0]           r_disp_q;
    logic [3:0]           r_tx_q;

    logic       w_hit;
    logic [1:0] w_hit_row;
    logic [1:0] w_hit_col;
    logic       w_done;
    logic [15:0] w_count_inc;
    logic       w_wr_en;
    logic [3:0] w_wr_data;
    logic [3:0] w_key;
    logic [3:0] w_disp_val;
    t_result    w_res;

    always_comb begin
        w_hit     = 1'b0;
        w_hit_row = r_row;
        w_hit_col = r_col;
        for (int r = 0; r < SCAN_ROWS; r++) begin
            for (int c = 0; c < SCAN_COLS; c++) begin
                if (i_key_matrix[r*4+c]) begin
                    w_hit     = 1'b1;
                    w_hit_row = 2'(r);
                    w_hit_col = 2'(c);
                end
            end
        end
    end

    assign w_done      = (r_count >= i_limit);
    assign w_count_inc = (r_count != 16'hFFFF) ? (r_count + 16'd1) : r_count;
    assign w_key       = key_lookup(r_row, r_col);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_row       = r_row;
        n_col       = r_col;
        n_wp        = r_wp;
        n_disp      = r_disp;
        n_tx_active = r_tx_active;
        n_tx_index  = r_tx_index;
        w_wr_en     = 1'b0;
        w_wr_data   = 4'd0;
        w_res       = '0;

        unique case (i_opcode)
            OP_SCAN: begin
                unique case (r_state)
                    ST_IDLE: begin
                        n_row = w_hit_row;
                        n_col = w_hit_col;
                        if (w_hit) begin
                            n_state = ST_PRESS;
                            n_count = 16'd0;
                        end
                    end
                    ST_PRESS: begin
                        n_row   = w_hit_row;
                        n_col   = w_hit_col;
                        n_count = w_count_inc;
                        if (w_done) begin
                            n_state = ST_PROCESS;
                        end
                    end
                    ST_PROCESS: begin
                        w_res.key_valid = 1'b1;
                        w_res.key_code  = w_key;
                        if (w_key < KEY_SEND) begin
                            w_wr_en   = 1'b1;
                            w_wr_data = w_key;
                        end
                        if (w_key == KEY_SEND) begin
                            n_tx_active = 1'b1;
                        end
                        n_state = ST_RELEASE;
                        n_count = 16'd0;
                    end
                    default: begin
                        n_row   = w_hit_row;
                        n_col   = w_hit_col;
                        n_count = w_count_inc;
                        if (w_done) begin
                            n_state = ST_IDLE;
                        end
                    end
                endcase
                w_res.display_valid = 1'b1;
                w_res.digit_select  = 2'(r_disp);
                w_res.seg_pattern   = seg_lookup(w_disp_val);
                n_disp = r_disp + 1'b1;
            end
            OP_RX: begin
                if (i_rx_byte >= ASCII_ZERO && i_rx_byte <= ASCII_NINE) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = i_rx_byte[3:0];
                end
            end
            OP_TXRDY: begin
                if (r_tx_active) begin
                    if ({1'b0, r_tx_index} < 4'(DIGITS)) begin
                        w_res.tx_valid = 1'b1;
                        w_res.tx_byte  = r_tx_q;
                        n_tx_index     = r_tx_index + 3'd1;
                    end else begin
                        n_tx_active = 1'b0;
                        n_tx_index  = 3'd0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_wr_en) begin
            n_wp = r_wp + 1'b1;
        end
    end

    assign w_disp_val = (w_wr_en && (r_wp == r_disp)) ? w_wr_data : r_disp_q;
    assign o_result   = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= 16'd0;
            r_row       <= 2'd0;
            r_col       <= 2'd0;
            r_wp        <= '0;
            r_disp      <= '0;
            r_tx_active <= 1'b0;
            r_tx_index  <= 3'd0;
        end else if (i_accept) begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_row       <= n_row;
            r_col       <= n_col;
            r_wp        <= n_wp;
            r_disp      <= n_disp;
            r_tx_active <= n_tx_active;
            r_tx_index  <= n_tx_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_wr_en) begin
            r_mem[r_wp] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
        end else if (i_accept && w_wr_en) begin
            r_mem_valid[r_wp] <= 1'b1;
        end
    end

    // prefetch the entries the next item will read, forwarding this write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_q <= 4'd0;
            r_tx_q   <= 4'd0;
        end else if (i_accept) begin
            if (w_wr_en && (r_wp == n_disp)) begin
                r_disp_q <= w_wr_data;
            end else if (r_mem_valid[n_disp]) begin
                r_disp_q <= r_mem[n_disp];
            end else begin
                r_disp_q <= 4'd0;
            end
            if (w_wr_en && (r_wp == n_tx_index[RING_AW-1:0])) begin
                r_tx_q <= w_wr_data;
            end else if (r_mem_valid[n_tx_index[RING_AW-1:0]]) begin
                r_tx_q <= r_mem[n_tx_index[RING_AW-1:0]];
            end else begin
                r_tx_q <= 4'd0;
            end
        end
    end

    `KPD_ASSERT_IMP(a_idle_tx_index, i_clk, i_rst_n, !r_tx_active, r_tx_index == 3'd0)
    `KPD_ASSERT_IMP(a_tx_index_bound, i_clk, i_rst_n, 1'b1, 4'(r_tx_index) <= 4'(DIGITS))
    `KPD_ASSERT_IMP(a_process_reports, i_clk, i_rst_n,
                    i_opcode == OP_SCAN && r_state == ST_PROCESS, w_res.key_valid)

endmodule

// ===== sv/keypad_debounce_digit_entry_top.sv =====
`timescale 1ns / 1ps
`include "keypad_debounce_digit_entry_top_assert.svh"

// 4x4 keypad scanner with debounce, four-digit ring, serial digit send and
// multiplexed seven-segment display. Every request (scan tick, received byte
// or transmitter-ready event) yields exactly one result.
// It is decoded against the held state in a single pass and the result lands
// in an output register backed by a one-entry skid register, so a request is
// taken every cycle while the output side keeps up, and one more while it
// stalls. The debounce limit register (reset 400) is written through the
// configuration channel, which is always ready; a debounce phase lasts
// limit+1 scan ticks.
module keypad_debounce_digit_entry_top #(
    parameter int DIGITS      = kpd_pkg::DIGITS_DEF,
    parameter int KEY_ROWS    = kpd_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLUMNS = kpd_pkg::KEY_COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kpd_in_if.sink     i_in,
    kpd_out_if.source  o_out,
    kpd_cfg_if.sink    i_cfg
);
    import kpd_pkg::*;

    logic [15:0] r_limit;
    logic        r_out_valid, n_out_valid;
    logic        r_skid_valid, n_skid_valid;
    t_result     r_out, n_out;
    t_result     r_skid, n_skid;
    t_result     w_res;
    logic        w_accept;
    logic        w_take;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign w_accept    = i_in.valid && !r_skid_valid;
    assign w_take      = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    kpd_engine #(
        .DIGITS      (DIGITS),
        .KEY_ROWS    (KEY_ROWS),
        .KEY_COLUMNS (KEY_COLUMNS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_opcode     (i_in.opcode),
        .i_key_matrix (i_in.key_matrix),
        .i_rx_byte    (i_in.rx_byte),
        .i_limit      (r_limit),
        .o_result     (w_res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_accept) begin
            if (!n_out_valid) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.display_valid = r_out.display_valid;
    assign o_out.digit_select  = r_out.digit_select;
    assign o_out.seg_pattern   = r_out.seg_pattern;
    assign o_out.key_valid     = r_out.key_valid;
    assign o_out.key_code      = r_out.key_code;
    assign o_out.tx_valid      = r_out.tx_valid;
    assign o_out.tx_byte       = r_out.tx_byte;

    `KPD_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `KPD_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, w_accept, r_out_valid)
    `KPD_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
                    w_accept && r_out_valid && !o_out.ready, r_skid_valid)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import kpd_pkg::*;

    localparam logic [1:0] OP_NONE        = 2'd3;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         LONG_HOLD      = 80;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         PARTIAL_HOLD   = 20;

    // entry n of each map sits at bits [n*w +: w]
    localparam logic [63:0]  KEY_CODES = 64'hE0FD_789C_456B_123A;
    localparam logic [127:0] SEG_CODES = 128'hFFFF_FFFF_FFFF_9080_F882_9299_B0A4_F9C0;

    typedef enum logic [1:0] {KP_IDLE, KP_PRESS, KP_PROCESS, KP_RELEASE} t_kp_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] key_matrix;
        logic [7:0]  rx_byte;
    } t_keypad_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kpd_in_if  in_bus ();
    kpd_out_if out_bus ();
    kpd_cfg_if cfg_bus ();

    keypad_debounce_digit_entry_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    t_keypad_req req_q[$];
    t_result     result_q[$];

    t_kp_state   kp_state       = KP_IDLE;
    logic [15:0] bounce_limit   = LIMIT_RESET;
    logic [15:0] bounce_cnt     = '0;
    logic [1:0]  latch_row      = '0;
    logic [1:0]  latch_col      = '0;
    logic [3:0]  digit_ring [4] = '{default: '0};
    logic [1:0]  ring_wr        = '0;
    logic [1:0]  disp_pos       = '0;
    logic        sending        = 1'b0;
    logic [2:0]  send_pos       = '0;

    bit req_offered   = 1'b0;
    bit sender_hold   = 1'b0;
    bit long_hold_req = 1'b0;
    bit calm          = 1'b0;
    bit cfg_taken     = 1'b0;
    int send_gap      = 0;
    int send_quiet    = 0;
    int recv_gap      = 0;
    int recv_quiet    = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int n_pushed      = 0;
    int n_requests    = 0;
    int n_results     = 0;
    int n_keys        = 0;
    int n_sent        = 0;
    int n_fail        = 0;

    function automatic void store_digit(input logic [3:0] v);
        digit_ring[ring_wr] = v;
        ring_wr++;
    endfunction

    function automatic void scan_matrix(input logic [15:0] m);
        for (int r = 0; r < KEY_ROWS_DEF; r++) begin
            for (int c = 0; c < KEY_COLUMNS_DEF; c++) begin
                if (m[r * 4 + c]) begin
                    latch_row = 2'(r);
                    latch_col = 2'(c);
                    if (kp_state == KP_IDLE) begin
                        kp_state   = KP_PRESS;
                        bounce_cnt = '0;
                    end
                end
            end
        end
    endfunction

    function automatic logic debounce_elapsed();
        logic done;
        done = (bounce_cnt >= bounce_limit);
        if (bounce_cnt != 16'hFFFF)
            bounce_cnt++;
        return done;
    endfunction

    function automatic t_result predict_keypad(input t_keypad_req r);
        t_result    res;
        logic [3:0] key;
        int         idx;
        res = '0;
        case (r.opcode)
            OP_SCAN: begin
                case (kp_state)
                    KP_IDLE: scan_matrix(r.key_matrix);
                    KP_PRESS: begin
                        scan_matrix(r.key_matrix);
                        if (debounce_elapsed())
                            kp_state = KP_PROCESS;
                    end
                    KP_PROCESS: begin
                        idx           = int'({latch_row, latch_col});
                        key           = KEY_CODES[idx * 4 +: 4];
                        res.key_valid = 1'b1;
                        res.key_code  = key;
                        if (key < 4'd10)
                            store_digit(key);
                        if (key == KEY_SEND)
                            sending = 1'b1;
                        kp_state   = KP_RELEASE;
                        bounce_cnt = '0;
                    end
                    default: begin
                        scan_matrix(r.key_matrix);
                        if (debounce_elapsed())
                            kp_state = KP_IDLE;
                    end
                endcase
                idx               = int'(digit_ring[disp_pos]);
                res.display_valid = 1'b1;
                res.digit_select  = disp_pos;
                res.seg_pattern   = SEG_CODES[idx * 8 +: 8];
                disp_pos++;
            end
            OP_RX: begin
                if (r.rx_byte >= ASCII_ZERO && r.rx_byte <= ASCII_NINE)
                    store_digit(4'(r.rx_byte - ASCII_ZERO));
            end
            OP_TXRDY: begin
                if (sending) begin
                    if (send_pos < DIGITS_DEF) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = digit_ring[send_pos[1:0]];
                        send_pos++;
                    end else begin
                        sending  = 1'b0;
                        send_pos = '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    // sender: offer the head of the queue, idle in bursts between requests
    always @(negedge i_clk) begin
        if (!req_offered) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (!i_rst_n || sender_hold || req_q.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (!calm && send_quiet == 0 && $urandom_range(0, 9) == 0) begin
                send_gap   = $urandom_range(1, 17) - 1;
                send_quiet = $urandom_range(0, 40);
                in_bus.valid <= 1'b0;
            end else begin
                if (send_quiet > 0)
                    send_quiet--;
                in_bus.valid      <= 1'b1;
                in_bus.opcode     <= req_q[0].opcode;
                in_bus.key_matrix <= req_q[0].key_matrix;
                in_bus.rx_byte    <= req_q[0].rx_byte;
                req_offered = 1'b1;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_bus.ready <= 1'b0;
        end else if (!calm && recv_quiet == 0 && $urandom_range(0, 11) == 0) begin
            recv_gap   = $urandom_range(1, 17) - 1;
            recv_quiet = $urandom_range(0, 40);
            out_bus.ready <= 1'b0;
        end else begin
            if (recv_quiet > 0)
                recv_quiet--;
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            result_q.push_back(predict_keypad(req_q[0]));
            req_q.pop_front();
            req_offered = 1'b0;
            n_requests++;
            moved = 1'b1;
        end
        if (i_rst_n && cfg_bus.valid && cfg_bus.ready) begin
            bounce_limit = cfg_bus.data;
            cfg_taken    = 1'b1;
            moved        = 1'b1;
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            moved = 1'b1;
            if (result_q.size() == 0) begin
                $error("result arrived with no request outstanding");
                n_fail++;
            end else begin
                want = result_q.pop_front();
                n_results++;
                if (want.key_valid)
                    n_keys++;
                if (want.tx_valid)
                    n_sent++;
                check_field("display_valid", want.display_valid, out_bus.display_valid);
                check_field("digit_select", want.digit_select, out_bus.digit_select);
                check_field("seg_pattern", want.seg_pattern, out_bus.seg_pattern);
                check_field("key_valid", want.key_valid, out_bus.key_valid);
                check_field("key_code", want.key_code, out_bus.key_code);
                check_field("tx_valid", want.tx_valid, out_bus.tx_valid);
                check_field("tx_byte", want.tx_byte, out_bus.tx_byte);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", idle_cycles);
            $display("keypad_debounce_digit_entry_top test failed");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] op, input logic [15:0] m, input logic [7:0] rx);
        t_keypad_req r;
        r.opcode     = op;
        r.key_matrix = m;
        r.rx_byte    = rx;
        req_q.push_back(r);
        n_pushed++;
    endtask

    task automatic push_press(input logic [15:0] m, input int held, input int released,
                              input bit noisy);
        logic [15:0] mm;
        for (int i = 0; i < held; i++) begin
            mm = m;
            if (noisy && $urandom_range(0, 4) == 0)
                mm = mm | 16'($urandom);
            push_req(OP_SCAN, mm, 8'($urandom));
        end
        for (int i = 0; i < released; i++) begin
            mm = (noisy && $urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0000;
            push_req(OP_SCAN, mm, 8'($urandom));
        end
    endtask

    // mostly whole key presses timed to the limit, mixed with serial traffic and noise
    task automatic push_random(input int count, input int lim);
        int base_n;
        int held;
        base_n = n_pushed;
        while (n_pushed - base_n < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    held = ($urandom_range(0, 5) == 0) ? $urandom_range(1, lim + 1)
                                                        : lim + 2 + $urandom_range(0, 2);
                    push_press(16'h0001 << $urandom_range(0, 15), held,
                               lim + 2 + $urandom_range(0, 2), 1'b1);
                end
                4: begin
                    push_press(16'h0001, lim + 2, lim + 2, 1'b0);
                    repeat ($urandom_range(1, 6))
                        push_req(OP_TXRDY, 16'($urandom), 8'($urandom));
                end
                5: begin
                    repeat ($urandom_range(1, 4))
                        push_req(OP_RX, 16'($urandom),
                                 ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : ASCII_ZERO + 8'($urandom_range(0, 9)));
                end
                6: begin
                    repeat ($urandom_range(1, 5))
                        push_req(OP_TXRDY, 16'($urandom), 8'($urandom));
                end
                7: begin
                    repeat ($urandom_range(1, 4))
                        push_req(2'($urandom), 16'($urandom), 8'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        push_req(OP_SCAN, $urandom_range(0, 1) ? 16'($urandom) : 16'h0000,
                                 8'($urandom));
                end
            endcase
        end
    endtask

    task automatic drain_and_settle();
        do
            @(negedge i_clk);
        while (req_q.size() != 0 || req_offered || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_taken = 1'b0;
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do
            @(negedge i_clk);
        while (!cfg_taken);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int lim;
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.opcode      = OP_SCAN;
        in_bus.key_matrix  = '0;
        in_bus.rx_byte     = '0;
        out_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.data       = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a press at the reset limit, too short to be decoded
        push_req(OP_RX, 16'h0000, ASCII_ZERO + 8'd5);
        push_press(16'h0001 << $urandom_range(0, 15), PARTIAL_HOLD, PARTIAL_HOLD, 1'b0);
        drain_and_settle();

        write_limit(16'd0);
        push_req(OP_TXRDY, 16'hFFFF, 8'hFF);
        push_req(OP_NONE, 16'hFFFF, 8'hFF);
        push_req(OP_RX, 16'hFFFF, ASCII_ZERO);
        push_req(OP_RX, 16'h0000, ASCII_NINE);
        push_req(OP_RX, 16'h0000, ASCII_ZERO - 8'd1);
        push_req(OP_RX, 16'h0000, ASCII_NINE + 8'd1);
        push_req(OP_RX, 16'h0000, 8'hFF);
        push_req(OP_RX, 16'h0000, 8'h00);
        push_press(16'hFFFF, 2, 2, 1'b0);
        push_press(16'h0001, 2, 2, 1'b0);
        repeat (2) push_req(OP_TXRDY, 16'h0000, 8'h00);
        push_press(16'h0001, 2, 2, 1'b0);
        repeat (3) push_req(OP_TXRDY, 16'h0000, 8'h00);
        drain_and_settle();

        for (int ph = 0; ph < 4; ph++) begin
            lim = (ph == 0) ? 1 : (ph == 1) ? 0 : (ph == 2) ? 3 : $urandom_range(2, 6);
            write_limit(16'(lim));
            push_random(120, lim);
            if (ph == 1) begin
                @(posedge i_clk);
                long_hold_req = 1'b1;
            end
            if (ph == 2) begin
                repeat (40) @(posedge i_clk);
                sender_hold = 1'b1;
                do
                    @(negedge i_clk);
                while (req_offered || result_q.size() != 0);
                @(posedge i_clk);
                sender_hold = 1'b0;
            end
            // leave the debounce machine idle
            repeat (20) push_req(OP_SCAN, 16'h0000, 8'h00);
            drain_and_settle();
        end

        write_limit(16'd2);
        @(posedge i_clk);
        calm = 1'b1;
        push_random(100, 2);
        drain_and_settle();

        $display("Ran %0d requests and %0d results: %0d keys decoded, %0d digits sent.",
                 n_requests, n_results, n_keys, n_sent);
        $display("Limits 0, 1, 3, 2 and a random one, after a short press at the reset limit.");
        if (n_fail == 0)
            $display("keypad_debounce_digit_entry_top test passed");
        else
            $display("keypad_debounce_digit_entry_top test failed");
        $finish;
    end

endmodule
